### rtl/integer_divider_64_core_defines.svh
// Assertion macros shared by the divider checker.
`ifndef INTEGER_DIVIDER_64_CORE_DEFINES_SVH
`define INTEGER_DIVIDER_64_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IDIV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("idiv assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define IDIV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("idiv assertion failed");

`endif

### rtl/idiv_pkg.sv
// Shared types, widths and mode codes of the 64-bit integer divider.
`default_nettype none
package idiv_pkg;
    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned STEPS  = WORD_W;
    localparam int unsigned CNT_W  = $clog2(STEPS);

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [OP_W-1:0]   t_op;

    localparam t_op OP_U64    = 3'd0;
    localparam t_op OP_S64    = 3'd1;
    localparam t_op OP_S64U32 = 3'd2;
    localparam t_op OP_U32    = 3'd3;
    localparam t_op OP_S32    = 3'd4;

    function automatic t_word zext32(input t_word v);
        return {{(WORD_W-HALF_W){1'b0}}, v[HALF_W-1:0]};
    endfunction

    function automatic t_word sext32(input t_word v);
        return {{(WORD_W-HALF_W){v[HALF_W-1]}}, v[HALF_W-1:0]};
    endfunction
endpackage
`default_nettype wire

### rtl/idiv_in_if.sv
// Request channel of the divider: mode, dividend and divisor.
`default_nettype none
interface idiv_in_if;
    import idiv_pkg::*;

    logic  valid;
    logic  ready;
    t_op   op;
    t_word dividend;
    t_word divisor;

    modport source (output valid, output op, output dividend, output divisor, input ready);
    modport sink   (input valid, input op, input dividend, input divisor, output ready);
endinterface
`default_nettype wire

### rtl/idiv_out_if.sv
// Result channel of the divider: quotient, remainder and divide-by-zero flag.
`default_nettype none
interface idiv_out_if;
    import idiv_pkg::*;

    logic  valid;
    logic  ready;
    t_word quotient;
    t_word remainder;
    logic  divide_by_zero;

    modport source (output valid, output quotient, output remainder, output divide_by_zero,
                    input ready);
    modport sink   (input valid, input quotient, input remainder, input divide_by_zero,
                    output ready);
endinterface
`default_nettype wire

### rtl/integer_divider_64_core.sv
// Top level of the 64-bit radix-2 restoring integer divider.
// The result beat becomes valid after 64 restoring steps of the shared subtractor
// and one sign fix-up (states S_RUN, S_FIX, then S_DONE).
// A zero divisor skips the steps; its result beat is valid in the cycle after the accepting edge.
// The block takes one item at a time and holds its result until the beat is taken.
// Reset (synchronous, active low) returns the sequencer to idle; there is no clearing pass.
`default_nettype none
module integer_divider_64_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    idiv_in_if.sink    i_in,
    idiv_out_if.source o_out
);
    import idiv_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIX, S_DONE} t_state;

    t_state          r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_word           r_nq, n_nq;
    t_word           r_rem, n_rem;
    t_word           r_den, n_den;
    t_op             r_op, n_op;
    logic            r_neg_q, n_neg_q;
    logic            r_neg_r, n_neg_r;
    t_word           r_q_out, n_q_out;
    t_word           r_r_out, n_r_out;
    logic            r_dz_out, n_dz_out;

    // Operand selection at the accepting edge.
    t_word a_sel, b_sel, a_mag, b_mag;
    logic  a_signed, b_signed, a_neg, b_neg;

    // Shared restoring step.
    t_word           shifted;
    logic [WORD_W:0] diff;
    logic            ge;

    // Sign fix-up.
    t_word q_fix, r_fixv;

    always_comb begin
        a_sel    = i_in.dividend;
        b_sel    = i_in.divisor;
        a_signed = 1'b0;
        b_signed = 1'b0;
        case (i_in.op)
            OP_S64: begin
                a_signed = 1'b1;
                b_signed = 1'b1;
            end
            OP_S64U32: begin
                a_signed = 1'b1;
                b_sel    = zext32(i_in.divisor);
            end
            OP_U32: begin
                a_sel = zext32(i_in.dividend);
                b_sel = zext32(i_in.divisor);
            end
            OP_S32: begin
                a_sel    = sext32(i_in.dividend);
                b_sel    = sext32(i_in.divisor);
                a_signed = 1'b1;
                b_signed = 1'b1;
            end
            default: begin
                a_signed = 1'b0;
            end
        endcase
        a_neg = a_signed & a_sel[WORD_W-1];
        b_neg = b_signed & b_sel[WORD_W-1];
        a_mag = a_neg ? (t_word'(0) - a_sel) : a_sel;
        b_mag = b_neg ? (t_word'(0) - b_sel) : b_sel;
    end

    // A set top bit means the partial remainder already exceeds any divisor.
    always_comb begin
        shifted = {r_rem[WORD_W-2:0], r_nq[WORD_W-1]};
        diff    = {1'b0, shifted} - {1'b0, r_den};
        ge      = r_rem[WORD_W-1] | ~diff[WORD_W];
    end

    // The remainder keeps the dividend's sign, so only its magnitude needs negating.
    always_comb begin
        q_fix  = r_neg_q ? (t_word'(0) - r_nq) : r_nq;
        r_fixv = r_neg_r ? (t_word'(0) - r_rem) : r_rem;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_nq     = r_nq;
        n_rem    = r_rem;
        n_den    = r_den;
        n_op     = r_op;
        n_neg_q  = r_neg_q;
        n_neg_r  = r_neg_r;
        n_q_out  = r_q_out;
        n_r_out  = r_r_out;
        n_dz_out = r_dz_out;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_op    = i_in.op;
                    n_nq    = a_mag;
                    n_den   = b_mag;
                    n_rem   = '0;
                    n_neg_q = a_neg ^ b_neg;
                    n_neg_r = a_neg;
                    n_cnt   = '1;
                    if (b_sel == '0) begin
                        n_q_out  = '0;
                        n_r_out  = a_sel;
                        n_dz_out = 1'b1;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                n_rem = ge ? diff[WORD_W-1:0] : shifted;
                n_nq  = {r_nq[WORD_W-2:0], ge};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                n_dz_out = 1'b0;
                n_q_out  = q_fix;
                n_r_out  = r_fixv;
                case (r_op)
                    OP_S64U32: n_r_out = zext32(r_fixv);
                    OP_S32: begin
                        n_q_out = sext32(q_fix);
                        n_r_out = sext32(r_fixv);
                    end
                    default: n_r_out = r_fixv;
                endcase
                n_state = S_DONE;
            end
            S_DONE: begin
                if (o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_nq     <= n_nq;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_op     <= n_op;
        r_neg_q  <= n_neg_q;
        r_neg_r  <= n_neg_r;
        r_q_out  <= n_q_out;
        r_r_out  <= n_r_out;
        r_dz_out <= n_dz_out;
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = (r_state == S_DONE);
    assign o_out.quotient       = r_q_out;
    assign o_out.remainder      = r_r_out;
    assign o_out.divide_by_zero = r_dz_out;
endmodule
`default_nettype wire

### rtl/idiv_checker.sv
// Port-level checker for the divider, bound to the top level.
`default_nettype none
`include "integer_divider_64_core_defines.svh"
module idiv_checker (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_in_valid,
    input wire logic                   i_in_ready,
    input wire logic                   i_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [idiv_pkg::WORD_W-1:0] i_quotient,
    input wire logic [idiv_pkg::WORD_W-1:0] i_remainder,
    input wire logic                   i_dz
);
    import idiv_pkg::*;

    logic in_beat;
    logic out_stall;

    assign in_beat   = i_in_valid & i_in_ready;
    assign out_stall = i_out_valid & ~i_out_ready;

    // Once an item is taken the block is busy in the next cycle.
    `IDIV_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_beat, !i_in_ready)
    // A pending result blocks new requests.
    `IDIV_ASSERT_NOW(a_no_accept_with_result, i_clk, i_rst_n, i_out_valid, !i_in_ready)
    // A zero divisor always reports a zero quotient.
    `IDIV_ASSERT_NOW(a_dz_quotient_zero, i_clk, i_rst_n, i_out_valid && i_dz,
                     i_quotient == '0)
    // A stalled result beat stays put.
    `IDIV_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, out_stall,
                      i_out_valid && $stable(i_quotient) && $stable(i_remainder) && $stable(i_dz))
endmodule

bind integer_divider_64_core idiv_checker u_idiv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_quotient  (o_out.quotient),
    .i_remainder (o_out.remainder),
    .i_dz        (o_out.divide_by_zero)
);
`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the 64-bit integer divider, checked against a predictor.
module tb;
    import idiv_pkg::*;

    localparam t_word WORD_MIN  = 64'h8000_0000_0000_0000;
    localparam t_word WORD_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam t_word ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam t_word HALF_MIN  = 64'h0000_0000_8000_0000;
    localparam t_word HALF_ONES = 64'h0000_0000_FFFF_FFFF;
    localparam int    RANDOM_REQUESTS = 1228;
    localparam int    LONG_HOLD_CYCLES = 600;
    localparam int    DRAIN_CYCLES = 80;

    typedef struct {
        t_op   op;
        t_word dividend;
        t_word divisor;
        bit    drain_first;
    } div_request_t;

    typedef struct packed {
        t_word quot;
        t_word rem;
        logic  dz;
    } div_result_t;

    typedef enum int {
        SHAPE_FULL, SHAPE_SHORT, SHAPE_SHORT_NEG, SHAPE_TINY, SHAPE_TINY_NEG, SHAPE_CORNER
    } operand_shape_e;

    typedef enum int {
        READY_ALWAYS, READY_COIN, READY_BURSTY, READY_STARVED
    } ready_pattern_e;

    logic i_clk;
    logic i_rst_n;

    idiv_in_if  req_if ();
    idiv_out_if res_if ();

    integer_divider_64_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    div_request_t   pending_requests[$];
    div_result_t    expected_results[$];
    int             requests_total;
    int             requests_sent;
    int             results_seen;
    int             failures;
    int             gap_left;
    int             burst_left;
    int             hold_left;
    bit             long_hold_done;
    int             pattern_left;
    int             run_left;
    ready_pattern_e ready_pattern;

    always #5 i_clk = ~i_clk;

    // Quotient truncates toward zero; the remainder wraps within the mode's width.
    function automatic div_result_t predict_division(t_op op, t_word a, t_word b);
        div_result_t res;
        t_word       mag_a;
        t_word       mag_b;
        t_word       wa;
        t_word       wb;
        t_word       diff;
        int          sa;
        int          sb;
        int          q32;
        int          r32;
        longint      ext;
        res = '0;
        case (op)
            OP_S64: begin
                if (b == 0) begin
                    res.dz  = 1'b1;
                    res.rem = a;
                end else begin
                    mag_a    = a[63] ? -a : a;
                    mag_b    = b[63] ? -b : b;
                    res.quot = mag_a / mag_b;
                    if (a[63] ^ b[63])
                        res.quot = -res.quot;
                    res.rem = a - res.quot * b;
                end
            end
            OP_S64U32: begin
                wb = {32'h0, b[31:0]};
                if (wb == 0) begin
                    res.dz  = 1'b1;
                    res.rem = a;
                end else begin
                    mag_a    = a[63] ? -a : a;
                    res.quot = mag_a / wb;
                    if (a[63])
                        res.quot = -res.quot;
                    diff    = a - res.quot * wb;
                    res.rem = {32'h0, diff[31:0]};
                end
            end
            OP_U32: begin
                wa = {32'h0, a[31:0]};
                wb = {32'h0, b[31:0]};
                if (wb == 0) begin
                    res.dz  = 1'b1;
                    res.rem = wa;
                end else begin
                    res.quot = wa / wb;
                    res.rem  = wa % wb;
                end
            end
            OP_S32: begin
                sa  = a[31:0];
                sb  = b[31:0];
                ext = sa;
                wa  = ext;
                ext = sb;
                wb  = ext;
                if (sb == 0) begin
                    res.dz  = 1'b1;
                    res.rem = wa;
                end else begin
                    mag_a = wa[63] ? -wa : wa;
                    mag_b = wb[63] ? -wb : wb;
                    diff  = mag_a / mag_b;
                    if (wa[63] ^ wb[63])
                        diff = -diff;
                    q32      = diff[31:0];
                    ext      = q32;
                    res.quot = ext;
                    diff     = wa - res.quot * wb;
                    r32      = diff[31:0];
                    ext      = r32;
                    res.rem  = ext;
                end
            end
            default: begin
                // Unused op codes divide as unsigned 64/64.
                if (b == 0) begin
                    res.dz  = 1'b1;
                    res.rem = a;
                end else begin
                    res.quot = a / b;
                    res.rem  = a % b;
                end
            end
        endcase
        return res;
    endfunction

    function automatic t_word shaped_operand();
        t_word          v;
        operand_shape_e shape;
        v     = {$urandom, $urandom};
        shape = operand_shape_e'($urandom_range(SHAPE_FULL, SHAPE_CORNER));
        case (shape)
            SHAPE_SHORT:     v = v >> $urandom_range(1, 63);
            SHAPE_SHORT_NEG: v = -(v >> $urandom_range(1, 63));
            SHAPE_TINY:      v = t_word'($urandom_range(0, 15));
            SHAPE_TINY_NEG:  v = -t_word'($urandom_range(1, 16));
            SHAPE_CORNER: begin
                case ($urandom_range(0, 6))
                    0: v = WORD_MIN;
                    1: v = WORD_MAX;
                    2: v = ALL_ONES;
                    3: v = HALF_MIN;
                    4: v = HALF_ONES;
                    5: v = HALF_MIN - 1;
                    default: v = 64'd1;
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic add_request(t_op op, t_word a, t_word b, bit drain_first);
        div_request_t r;
        r.op          = op;
        r.dividend    = a;
        r.divisor     = b;
        r.drain_first = drain_first;
        pending_requests.push_back(r);
    endtask

    // Request driver: bursts of beats separated by idle gaps.
    always @(posedge i_clk) begin
        div_request_t nxt;
        logic         offer;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            gap_left     = 0;
            burst_left   = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_results.push_back(
                    predict_division(req_if.op, req_if.dividend, req_if.divisor));
                requests_sent++;
            end
            if (!req_if.valid || req_if.ready) begin
                offer = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_requests.size() > 0 &&
                             !(pending_requests[0].drain_first &&
                               expected_results.size() != 0)) begin
                    nxt             = pending_requests.pop_front();
                    offer           = 1'b1;
                    req_if.op       <= nxt.op;
                    req_if.dividend <= nxt.dividend;
                    req_if.divisor  <= nxt.divisor;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 8);
                        if ($urandom_range(0, 3) == 0)
                            gap_left = 0;
                        else if ($urandom_range(0, 7) == 0)
                            gap_left = $urandom_range(13, 90);
                        else
                            gap_left = $urandom_range(1, 12);
                    end
                end
                req_if.valid <= offer;
            end
        end
    end

    // Result receiver: switches between stall patterns, with one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready   <= 1'b0;
            hold_left      = 0;
            long_hold_done = 1'b0;
            pattern_left   = 0;
            run_left       = 0;
            ready_pattern  = READY_ALWAYS;
        end else if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= 300) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD_CYCLES;
            res_if.ready   <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                ready_pattern = ready_pattern_e'($urandom_range(READY_ALWAYS, READY_STARVED));
                pattern_left  = $urandom_range(50, 400);
            end else begin
                pattern_left--;
            end
            case (ready_pattern)
                READY_COIN:    res_if.ready <= 1'($urandom_range(0, 1));
                READY_STARVED: res_if.ready <= ($urandom_range(0, 3) == 0);
                READY_BURSTY: begin
                    if (run_left == 0) begin
                        run_left     = $urandom_range(1, 6);
                        res_if.ready <= ~res_if.ready;
                    end else begin
                        run_left--;
                    end
                end
                default:       res_if.ready <= 1'b1;
            endcase
        end
    end

    // Result monitor: every beat is matched against the oldest prediction.
    always @(posedge i_clk) begin
        div_result_t want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result beat with no request outstanding: quotient %h remainder %h",
                       res_if.quotient, res_if.remainder);
                failures++;
            end else begin
                want = expected_results.pop_front();
                if (res_if.quotient !== want.quot) begin
                    $error("quotient: expected %h, actual %h", want.quot, res_if.quotient);
                    failures++;
                end
                if (res_if.remainder !== want.rem) begin
                    $error("remainder: expected %h, actual %h", want.rem, res_if.remainder);
                    failures++;
                end
                if (res_if.divide_by_zero !== want.dz) begin
                    $error("divide_by_zero: expected %b, actual %b",
                           want.dz, res_if.divide_by_zero);
                    failures++;
                end
            end
        end
    end

    initial begin
        t_op   op;
        t_word a;
        t_word b;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.op       = OP_U64;
        req_if.dividend = '0;
        req_if.divisor  = '0;
        res_if.ready    = 1'b0;
        requests_sent   = 0;
        results_seen    = 0;
        failures        = 0;

        // Directed corners: extremes, zero divisors in every mode, most negative by minus one.
        add_request(OP_U64,    ALL_ONES, 64'd1, 1'b0);
        add_request(OP_U64,    64'd0, ALL_ONES, 1'b0);
        add_request(OP_U64,    ALL_ONES, ALL_ONES, 1'b0);
        add_request(OP_U64,    64'd1, ALL_ONES, 1'b0);
        add_request(OP_U64,    ALL_ONES, WORD_MIN, 1'b0);
        add_request(OP_U64,    64'h0123_4567_89AB_CDEF, 64'd0, 1'b0);
        add_request(OP_S64,    WORD_MIN, ALL_ONES, 1'b0);
        add_request(OP_S64,    WORD_MIN, 64'd1, 1'b0);
        add_request(OP_S64,    -t_word'(7), 64'd2, 1'b0);
        add_request(OP_S64,    64'd7, -t_word'(2), 1'b0);
        add_request(OP_S64,    WORD_MAX, WORD_MIN, 1'b0);
        add_request(OP_S64,    -t_word'(5), 64'd0, 1'b0);
        add_request(OP_S64U32, ALL_ONES, 64'hDEAD_BEEF_0000_0003, 1'b0);
        add_request(OP_S64U32, WORD_MIN, HALF_ONES, 1'b0);
        add_request(OP_S64U32, WORD_MAX, 64'hFFFF_FFFF_8000_0001, 1'b0);
        add_request(OP_S64U32, WORD_MIN, 64'h1234_5678_0000_0000, 1'b0);
        add_request(OP_U32,    ALL_ONES, 64'hFFFF_FFFF_0000_0001, 1'b0);
        add_request(OP_U32,    64'h5555_5555_AAAA_AAAA, 64'hFFFF_FFFF_0000_0000, 1'b0);
        add_request(OP_S32,    HALF_MIN, HALF_ONES, 1'b0);
        add_request(OP_S32,    64'hABCD_0000_FFFF_FFF9, 64'h0000_1234_0000_0002, 1'b0);
        add_request(OP_S32,    64'h0000_0000_8000_0005, 64'h7777_7777_0000_0000, 1'b0);
        add_request(OP_S32,    HALF_MIN - 1, HALF_MIN, 1'b0);
        add_request(3'd5,      ALL_ONES, 64'd3, 1'b0);
        add_request(3'd6,      WORD_MIN, 64'd0, 1'b0);
        add_request(3'd7,      64'hFEDC_BA98_7654_3210, 64'h0000_0001_0000_0000, 1'b0);

        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            if ($urandom_range(0, 9) == 0)
                op = t_op'($urandom_range(5, 7));
            else
                op = t_op'($urandom_range(OP_U64, OP_S32));
            a = shaped_operand();
            b = shaped_operand();
            if (op inside {OP_S64U32, OP_U32, OP_S32} && $urandom_range(0, 2) == 0) begin
                a[63:32] = $urandom;
                b[63:32] = $urandom;
            end
            if ($urandom_range(0, 24) == 0)
                b = (op inside {OP_S64U32, OP_U32, OP_S32}) ? {$urandom, 32'h0} : '0;
            // The sender pauses for a full drain after the directed corners and midway.
            add_request(op, a, b, i == 0 || i == RANDOM_REQUESTS / 2);
        end
        requests_total = pending_requests.size();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_sent < requests_total || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
